// ===== rtl/frpc_pkg.sv =====
// Shared definitions for the framed payload receiver: command and event codes,
// register indexes, header layout constants and the byte-wide CRC-32 update.
// No dependencies; every other file of the block but frpc_fifo imports this package.
`timescale 1ns / 1ps

package frpc_pkg;

	localparam int HEADER_BYTES_DEF = 12;
	localparam int INDEX_BITS_DEF = 16;
	localparam int COUNTER_BITS_DEF = 32;
	localparam int CMD_QUEUE_DEPTH = 2;
	localparam int RES_QUEUE_DEPTH = 2;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;
	localparam logic [31:0] MAGIC_FRM1 = 32'h314D_5246;
	localparam logic [15:0] LEN_CAP = 16'hFFFE;
	localparam logic [15:0] MAX_PAYLOAD_RST = 16'd65534;
	localparam logic [15:0] STUCK_TIMEOUT_RST = 16'd300;

	// input function codes
	localparam logic [2:0] FUNC_DATA = 3'd0;
	localparam logic [2:0] FUNC_TICK = 3'd1;
	localparam logic [2:0] FUNC_LINK = 3'd2;
	localparam logic [2:0] FUNC_SELECT = 3'd3;
	localparam logic [2:0] FUNC_RELEASE = 3'd4;

	// result event codes
	localparam logic [2:0] EV_NONE = 3'd0;
	localparam logic [2:0] EV_ACCEPTED = 3'd1;
	localparam logic [2:0] EV_BAD_HEADER = 3'd2;
	localparam logic [2:0] EV_BAD_CRC = 3'd3;
	localparam logic [2:0] EV_LINK_ERROR = 3'd4;
	localparam logic [2:0] EV_STUCK = 3'd5;
	localparam logic [2:0] EV_RELEASED = 3'd6;

	// configuration register indexes
	localparam logic REG_MAX_PAYLOAD = 1'b0;
	localparam logic REG_STUCK_TIMEOUT = 1'b1;

	typedef enum logic [2:0] {
		OP_DATA,
		OP_TICK,
		OP_LINK,
		OP_SELECT,
		OP_RELEASE,
		OP_IGNORE
	} op_t;

	typedef struct packed {
		op_t op;
		logic [7:0] data;
	} cmd_t;

	// reflected CRC-32, one byte, LSB first
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== rtl/frpc_fifo.sv =====
// Small flop-based queue with full/empty flags decoded from a registered count.
// Used for the command queue and the result queue; depends on nothing.
`timescale 1ns / 1ps

module frpc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign full = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign dout = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

endmodule

// ===== rtl/frpc_front.sv =====
// Front end: takes input requests, classifies the function code and queues
// the decoded command. Depends on frpc_pkg and frpc_fifo.
`timescale 1ns / 1ps

module frpc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  logic [2:0]     func,
	input  logic [7:0]     data,
	input  logic           cmd_pop,
	output frpc_pkg::cmd_t cmd,
	output logic           cmd_empty
);

	import frpc_pkg::*;

	cmd_t cmd_in;

	always_comb begin
		cmd_in.data = data;
		unique case (func)
			FUNC_DATA:    cmd_in.op = OP_DATA;
			FUNC_TICK:    cmd_in.op = OP_TICK;
			FUNC_LINK:    cmd_in.op = OP_LINK;
			FUNC_SELECT:  cmd_in.op = OP_SELECT;
			FUNC_RELEASE: cmd_in.op = OP_RELEASE;
			default:      cmd_in.op = OP_IGNORE;
		endcase
	end

	frpc_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(CMD_QUEUE_DEPTH)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (cmd_in),
		.full  (full),
		.pop   (cmd_pop),
		.dout  (cmd),
		.empty (cmd_empty)
	);

endmodule

// ===== rtl/frpc_back.sv =====
// Back end: header parsing, payload forwarding with CRC-32 check, timeout,
// READY line, error counters and configuration registers. Depends on frpc_pkg.
`timescale 1ns / 1ps

module frpc_back #(
	parameter int INDEX_BITS = frpc_pkg::INDEX_BITS_DEF,
	parameter int COUNTER_BITS = frpc_pkg::COUNTER_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_en,
	input  logic                    wr_index,
	input  logic [15:0]             wr_data,
	input  frpc_pkg::cmd_t          cmd,
	input  logic                    cmd_valid,
	output logic                    cmd_pop,
	input  logic                    res_full,
	output logic                    res_push,
	output logic [2:0]              event_res,
	output logic                    byte_valid,
	output logic [7:0]              payload_byte,
	output logic [INDEX_BITS-1:0]   byte_index,
	output logic                    last_byte,
	output logic                    ready_res,
	output logic [15:0]             frame_length,
	output logic [COUNTER_BITS-1:0] bad_header_total,
	output logic [COUNTER_BITS-1:0] bad_crc_total,
	output logic [COUNTER_BITS-1:0] link_error_total,
	output logic [COUNTER_BITS-1:0] stuck_total
);

	import frpc_pkg::*;

	localparam logic [1:0] MODE_HEADER = 2'd0;
	localparam logic [1:0] MODE_PAYLOAD = 2'd1;
	localparam logic [1:0] MODE_HOLD = 2'd2;

	localparam int STORED_BYTES = HEADER_BYTES_DEF - 1;
	localparam logic [3:0] LAST_HDR = 4'(HEADER_BYTES_DEF - 1);
	localparam logic [31:0] IDX_CAP = 32'((64'd1 << INDEX_BITS) - 64'd2);
	localparam logic [16:0] WAIT_SAT = 17'h1_0000;

	logic [15:0]             max_payload_q;
	logic [15:0]             stuck_timeout_q;
	logic [1:0]              mode_q, mode_d;
	logic [3:0]              hdr_cnt_q, hdr_cnt_d;
	logic [7:0]              hdr_q [STORED_BYTES];
	logic [31:0]             exp_crc_q, exp_crc_d;
	logic [15:0]             pay_len_q, pay_len_d;
	logic [INDEX_BITS-1:0]   pay_cnt_q, pay_cnt_d;
	logic [31:0]             crc_q, crc_d;
	logic [16:0]             wait_q, wait_d;
	logic                    ready_q, ready_d;
	logic [COUNTER_BITS-1:0] hdr_err_q, hdr_err_d;
	logic [COUNTER_BITS-1:0] crc_err_q, crc_err_d;
	logic [COUNTER_BITS-1:0] link_err_q, link_err_d;
	logic [COUNTER_BITS-1:0] stuck_q, stuck_d;

	logic                    step;
	logic                    hdr_we;
	logic [31:0]             limit;
	logic [31:0]             magic_w, len_w, crc_w;
	logic [31:0]             crc_next;
	logic [INDEX_BITS-1:0]   cnt_next;
	logic [16:0]             wait_inc;

	assign step = cmd_valid && !res_full;
	assign cmd_pop = step;
	assign res_push = step;

	// effective length limit: register, capped by the fixed cap and the index range
	always_comb begin
		limit = {16'd0, max_payload_q};
		if (limit > {16'd0, LEN_CAP}) begin
			limit = {16'd0, LEN_CAP};
		end
		if (limit > IDX_CAP) begin
			limit = IDX_CAP;
		end
	end

	assign magic_w = {hdr_q[3], hdr_q[2], hdr_q[1], hdr_q[0]};
	assign len_w = {hdr_q[7], hdr_q[6], hdr_q[5], hdr_q[4]};
	assign crc_w = {cmd.data, hdr_q[10], hdr_q[9], hdr_q[8]};
	assign crc_next = crc32_byte(crc_q, cmd.data);
	assign cnt_next = pay_cnt_q + 1'b1;
	assign wait_inc = (wait_q < WAIT_SAT) ? wait_q + 1'b1 : wait_q;

	always_comb begin
		mode_d = mode_q;
		hdr_cnt_d = hdr_cnt_q;
		exp_crc_d = exp_crc_q;
		pay_len_d = pay_len_q;
		pay_cnt_d = pay_cnt_q;
		crc_d = crc_q;
		wait_d = wait_q;
		ready_d = ready_q;
		hdr_err_d = hdr_err_q;
		crc_err_d = crc_err_q;
		link_err_d = link_err_q;
		stuck_d = stuck_q;
		hdr_we = 1'b0;
		event_res = EV_NONE;
		byte_valid = 1'b0;
		payload_byte = '0;
		byte_index = '0;
		last_byte = 1'b0;

		unique case (cmd.op)
			OP_DATA: begin
				unique case (mode_q)
					MODE_HEADER: begin
						if (hdr_cnt_q == LAST_HDR) begin
							if (magic_w == MAGIC_FRM1 && len_w != '0 && len_w <= limit) begin
								mode_d = MODE_PAYLOAD;
								pay_len_d = len_w[15:0];
								exp_crc_d = crc_w;
								pay_cnt_d = '0;
								crc_d = CRC_ONES;
								wait_d = '0;
								hdr_cnt_d = '0;
							end else begin
								hdr_err_d = hdr_err_q + 1'b1;
								mode_d = MODE_HEADER;
								hdr_cnt_d = '0;
								ready_d = 1'b1;
								event_res = EV_BAD_HEADER;
							end
						end else begin
							hdr_we = 1'b1;
							hdr_cnt_d = hdr_cnt_q + 1'b1;
						end
					end
					MODE_PAYLOAD: begin
						byte_valid = 1'b1;
						payload_byte = cmd.data;
						byte_index = pay_cnt_q;
						crc_d = crc_next;
						pay_cnt_d = cnt_next;
						if (32'(cnt_next) >= {16'd0, pay_len_q}) begin
							last_byte = 1'b1;
							if ((crc_next ^ CRC_ONES) == exp_crc_q) begin
								mode_d = MODE_HOLD;
								event_res = EV_ACCEPTED;
							end else begin
								crc_err_d = crc_err_q + 1'b1;
								mode_d = MODE_HEADER;
								hdr_cnt_d = '0;
								ready_d = 1'b1;
								event_res = EV_BAD_CRC;
							end
						end
					end
					default: begin
						// drop data while a frame is held
					end
				endcase
			end
			OP_TICK: begin
				if (mode_q == MODE_PAYLOAD) begin
					wait_d = wait_inc;
					if (wait_inc > {1'b0, stuck_timeout_q}) begin
						stuck_d = stuck_q + 1'b1;
						mode_d = MODE_HEADER;
						hdr_cnt_d = '0;
						ready_d = 1'b1;
						event_res = EV_STUCK;
					end
				end
			end
			OP_LINK: begin
				link_err_d = link_err_q + 1'b1;
				mode_d = MODE_HEADER;
				hdr_cnt_d = '0;
				ready_d = 1'b1;
				event_res = EV_LINK_ERROR;
			end
			OP_SELECT: begin
				ready_d = 1'b0;
			end
			OP_RELEASE: begin
				if (mode_q == MODE_HOLD) begin
					mode_d = MODE_HEADER;
					hdr_cnt_d = '0;
					ready_d = 1'b1;
					event_res = EV_RELEASED;
				end
			end
			default: begin
			end
		endcase

		ready_res = ready_d;
		frame_length = (mode_d != MODE_HEADER) ? pay_len_d : '0;
		bad_header_total = hdr_err_d;
		bad_crc_total = crc_err_d;
		link_error_total = link_err_d;
		stuck_total = stuck_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RST;
			stuck_timeout_q <= STUCK_TIMEOUT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MAX_PAYLOAD:   max_payload_q <= wr_data;
				REG_STUCK_TIMEOUT: stuck_timeout_q <= wr_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_HEADER;
			hdr_cnt_q <= '0;
			exp_crc_q <= '0;
			pay_len_q <= '0;
			pay_cnt_q <= '0;
			crc_q <= CRC_ONES;
			wait_q <= '0;
			ready_q <= 1'b1;
			hdr_err_q <= '0;
			crc_err_q <= '0;
			link_err_q <= '0;
			stuck_q <= '0;
		end else if (step) begin
			mode_q <= mode_d;
			hdr_cnt_q <= hdr_cnt_d;
			exp_crc_q <= exp_crc_d;
			pay_len_q <= pay_len_d;
			pay_cnt_q <= pay_cnt_d;
			crc_q <= crc_d;
			wait_q <= wait_d;
			ready_q <= ready_d;
			hdr_err_q <= hdr_err_d;
			crc_err_q <= crc_err_d;
			link_err_q <= link_err_d;
			stuck_q <= stuck_d;
		end
	end

	// header bytes are always overwritten in order before the header is judged
	always_ff @(posedge clk) begin
		if (step && hdr_we) begin
			hdr_q[hdr_cnt_q] <= cmd.data;
		end
	end

endmodule

// ===== rtl/framed_payload_receiver_crc32_core.sv =====
// Top level of the framed payload receiver: front end, back end, result queue.
// Depends on frpc_pkg, frpc_fifo, frpc_front and frpc_back.
`timescale 1ns / 1ps

// Every request (data byte, tick, link error, select fall, release) yields
// exactly one result. One request is accepted per clock while the command
// queue is not full. Requests pass through the command queue and their results
// are registered into the result queue. The rate is set by the back end, which
// applies one request per cycle while the result queue is not full, including a
// full byte-wide CRC-32 update. A two-entry command queue and a two-entry result
// queue decouple the input and output sides. There is no clearing pass after
// reset. Configuration writes are taken at any time but belong in idle periods.
module framed_payload_receiver_crc32_core #(
	parameter int INDEX_BITS = frpc_pkg::INDEX_BITS_DEF,
	parameter int COUNTER_BITS = frpc_pkg::COUNTER_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_en,
	input  logic                    wr_index,
	input  logic [15:0]             wr_data,
	input  logic                    push,
	output logic                    full,
	input  logic [2:0]              func,
	input  logic [7:0]              data,
	output logic                    empty,
	input  logic                    pop,
	output logic [2:0]              event_res,
	output logic                    byte_valid,
	output logic [7:0]              payload_byte,
	output logic [INDEX_BITS-1:0]   byte_index,
	output logic                    last_byte,
	output logic                    ready_res,
	output logic [15:0]             frame_length,
	output logic [COUNTER_BITS-1:0] bad_header_total,
	output logic [COUNTER_BITS-1:0] bad_crc_total,
	output logic [COUNTER_BITS-1:0] link_error_total,
	output logic [COUNTER_BITS-1:0] stuck_total
);

	import frpc_pkg::*;

	localparam int RES_W = 3 + 1 + 8 + INDEX_BITS + 1 + 1 + 16 + 4 * COUNTER_BITS;

	cmd_t                    cmd;
	logic                    cmd_empty;
	logic                    cmd_pop;
	logic                    res_full;
	logic                    res_push;
	logic [RES_W-1:0]        res_din;
	logic [RES_W-1:0]        res_dout;

	logic [2:0]              b_event;
	logic                    b_valid;
	logic [7:0]              b_byte;
	logic [INDEX_BITS-1:0]   b_index;
	logic                    b_last;
	logic                    b_ready;
	logic [15:0]             b_len;
	logic [COUNTER_BITS-1:0] b_hdr_err;
	logic [COUNTER_BITS-1:0] b_crc_err;
	logic [COUNTER_BITS-1:0] b_link_err;
	logic [COUNTER_BITS-1:0] b_stuck;

	frpc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.func     (func),
		.data     (data),
		.cmd_pop  (cmd_pop),
		.cmd      (cmd),
		.cmd_empty(cmd_empty)
	);

	frpc_back #(
		.INDEX_BITS  (INDEX_BITS),
		.COUNTER_BITS(COUNTER_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.cmd             (cmd),
		.cmd_valid       (!cmd_empty),
		.cmd_pop         (cmd_pop),
		.res_full        (res_full),
		.res_push        (res_push),
		.event_res       (b_event),
		.byte_valid      (b_valid),
		.payload_byte    (b_byte),
		.byte_index      (b_index),
		.last_byte       (b_last),
		.ready_res       (b_ready),
		.frame_length    (b_len),
		.bad_header_total(b_hdr_err),
		.bad_crc_total   (b_crc_err),
		.link_error_total(b_link_err),
		.stuck_total     (b_stuck)
	);

	assign res_din = {b_event, b_valid, b_byte, b_index, b_last, b_ready, b_len,
		b_hdr_err, b_crc_err, b_link_err, b_stuck};

	frpc_fifo #(
		.WIDTH(RES_W),
		.DEPTH(RES_QUEUE_DEPTH)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.din   (res_din),
		.full  (res_full),
		.pop   (pop),
		.dout  (res_dout),
		.empty (empty)
	);

	assign {event_res, byte_valid, payload_byte, byte_index, last_byte, ready_res, frame_length,
		bad_header_total, bad_crc_total, link_error_total, stuck_total} = res_dout;

endmodule
